[src/ple_pkg.sv]
// shared types and constants of the positional list engine
// no dependencies; imported by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int CMD_W     = 3;
   localparam int POS_W     = 8;
   localparam int VAL_W     = 32;
   localparam int STAT_W    = 2;
   localparam int LEN_OUT_W = 5;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_END   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_POS   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_END   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_DELETE,
      OP_ROTATE
   } op_type;

   typedef enum logic [1:0] {
      SLOT_FRONT,
      SLOT_END,
      SLOT_POS
   } slot_sel_type;

   typedef struct packed {
      op_type             op;
      slot_sel_type       slot_sel;
      logic               load_rsp;
      logic               dump_item;
      logic [STAT_W-1:0]  status;
      logic               last;
      logic               clear_cnt;
   } ctrl_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic ins_pos_ok;
      logic del_pos_ok;
      logic dump_final;
   } dp_stat_type;

endpackage

`default_nettype wire

[src/ple_datapath.sv]
// list storage as shift cells, length count, dump counter and result register
// depends on ple_pkg; driven by ple_ctrl through ctrl_cmd_type
`timescale 1ns / 1ps
`default_nettype none

module ple_datapath
   import ple_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [POS_W-1:0]      req_position,
   input  wire logic [VAL_W-1:0]      req_value,
   input  wire ctrl_cmd_type          cmd,
   output dp_stat_type                stat,
   output logic      [VAL_W-1:0]      rsp_value,
   output logic      [STAT_W-1:0]     rsp_status,
   output logic      [LEN_OUT_W-1:0]  rsp_length,
   output logic                       rsp_last
);

   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

   logic [VAL_W-1:0] cell_ff [DEPTH];
   logic [VAL_W-1:0] cell_in [DEPTH];
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] slot;
   logic [LEN_W-1:0] len_m1;
   logic [CMP_W-1:0] pos_ext, len_ext;

   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [LEN_OUT_W-1:0] rsp_length_ff, rsp_length_in;
   logic                 rsp_last_ff, rsp_last_in;

   assign len_m1  = len_ff - LEN_W'(1);
   assign pos_ext = CMP_W'(req_position);
   assign len_ext = CMP_W'(len_ff);

   always_comb begin
      stat.empty      = (len_ff == '0);
      stat.full       = (len_ff == LEN_W'(DEPTH));
      stat.ins_pos_ok = (pos_ext != '0) && (pos_ext <= len_ext + CMP_W'(1));
      stat.del_pos_ok = (pos_ext != '0) && (pos_ext <= len_ext);
      stat.dump_final = (cnt_ff == len_m1);
   end

   // slot is only used when the position checks passed, so pos-1 fits
   always_comb begin
      case (cmd.slot_sel)
         SLOT_FRONT: slot = '0;
         SLOT_END:   slot = (cmd.op == OP_INSERT) ? len_ff : len_m1;
         SLOT_POS:   slot = LEN_W'(req_position - POS_W'(1));
         default:    slot = '0;
      endcase
   end

   // each cell picks from itself, a neighbor, the head cell or the new value
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VAL_W-1:0] right;
      if (i < DEPTH - 1) begin : g_right
         assign right = cell_ff[i+1];
      end else begin : g_edge
         assign right = cell_ff[i];
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         case (cmd.op)
            OP_INSERT: begin
               if (LEN_W'(i) == slot) begin
                  cell_in[i] = req_value;
               end else if (LEN_W'(i) > slot) begin
                  if (i > 0) begin
                     cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
                  end
               end
            end
            OP_DELETE: begin
               if (LEN_W'(i) >= slot) begin
                  cell_in[i] = right;
               end
            end
            OP_ROTATE: begin
               // head moves to the tail, the rest move one toward the head
               if (LEN_W'(i) == len_m1) begin
                  cell_in[i] = cell_ff[0];
               end else if (LEN_W'(i) < len_m1) begin
                  cell_in[i] = right;
               end
            end
            default: cell_in[i] = cell_ff[i];
         endcase
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   always_comb begin
      case (cmd.op)
         OP_INSERT: len_in = len_ff + LEN_W'(1);
         OP_DELETE: len_in = len_m1;
         default:   len_in = len_ff;
      endcase

      if (cmd.clear_cnt) begin
         cnt_in = '0;
      end else if (cmd.op == OP_ROTATE) begin
         cnt_in = cnt_ff + LEN_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end

      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.load_rsp) begin
         rsp_value_in  = cmd.dump_item ? cell_ff[0] : '0;
         rsp_status_in = cmd.status;
         rsp_length_in = LEN_OUT_W'(len_in);
         rsp_last_in   = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         cnt_ff <= '0;
      end else begin
         len_ff <= len_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

[src/ple_ctrl.sv]
// controller: request decode, status selection and dump sequencing
// depends on ple_pkg; commands ple_datapath through ctrl_cmd_type
`timescale 1ns / 1ps
`default_nettype none

module ple_ctrl
   import ple_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [CMD_W-1:0]  req_command,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire dp_stat_type       stat,
   output ctrl_cmd_type           cmd
);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   // the result register can take a new value when empty or being drained
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd.op        = OP_NONE;
      cmd.slot_sel  = SLOT_FRONT;
      cmd.load_rsp  = 1'b0;
      cmd.dump_item = 1'b0;
      cmd.status    = ST_OK;
      cmd.last      = 1'b1;
      cmd.clear_cnt = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_rsp = 1'b1;
               unique case (req_command) inside
                  CMD_ADD_FRONT, CMD_ADD_END, CMD_ADD_POS: begin
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else if (req_command == CMD_ADD_POS && !stat.ins_pos_ok) begin
                        cmd.status = ST_RANGE;
                     end else begin
                        cmd.op = OP_INSERT;
                        cmd.slot_sel = (req_command == CMD_ADD_FRONT) ? SLOT_FRONT :
                                       (req_command == CMD_ADD_END)   ? SLOT_END : SLOT_POS;
                     end
                  end
                  CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else if (req_command == CMD_DEL_POS && !stat.del_pos_ok) begin
                        cmd.status = ST_RANGE;
                     end else begin
                        cmd.op = OP_DELETE;
                        cmd.slot_sel = (req_command == CMD_DEL_FRONT) ? SLOT_FRONT :
                                       (req_command == CMD_DEL_END)   ? SLOT_END : SLOT_POS;
                     end
                  end
                  CMD_DUMP: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.load_rsp  = 1'b0;
                        cmd.clear_cnt = 1'b1;
                        state_in      = S_DUMP;
                     end
                  end
                  default: cmd.status = ST_OK;
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               cmd.op        = OP_ROTATE;
               cmd.load_rsp  = 1'b1;
               cmd.dump_item = 1'b1;
               cmd.last      = stat.dump_final;
               if (stat.dump_final) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[src/positional_list_engine.sv]
// Ordered list of up to DEPTH signed 32-bit values with insert and delete at the
// front, the end or a 1-based position, and a dump of all entries. Any command
// other than a dump of a non-empty list is decoded and applied to the shift
// cells at the clock edge that accepts it, and its single result lands in the
// output register at that same edge, so such commands go at one per cycle
// while the result side keeps up. A dump of N entries first clears the dump
// counter, then gives one entry per cycle as the cells rotate the head entry
// to the tail, paced by rsp_tready; no request is taken meanwhile.
// A failed command answers with an error status and leaves the list alone.
// Depends on ple_pkg, ple_ctrl and ple_datapath.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine
   import ple_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // command [2:0], position [10:3], value [42:11], zero fill above
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // item_value [31:0], status [33:32], list_length [38:34], zero fill above
   output logic      [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast
);

   ctrl_cmd_type         cmd;
   dp_stat_type          stat;
   logic [CMD_W-1:0]     req_command;
   logic [POS_W-1:0]     req_position;
   logic [VAL_W-1:0]     req_value;
   logic [VAL_W-1:0]     rsp_value;
   logic [STAT_W-1:0]    rsp_status;
   logic [LEN_OUT_W-1:0] rsp_length;

   assign req_command  = req_tdata[CMD_W-1:0];
   assign req_position = req_tdata[CMD_W+POS_W-1:CMD_W];
   assign req_value    = req_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W];

   ple_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_command),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .stat        (stat),
      .cmd         (cmd)
   );

   ple_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_position (req_position),
      .req_value    (req_value),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_value    (rsp_value),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W - VAL_W - STAT_W - LEN_OUT_W){1'b0}},
                       rsp_length, rsp_status, rsp_value};

endmodule

`default_nettype wire
